[src/ifaf_pkg.sv]
// Shared types, microcode encodings and constants for the integer field formatter.
package ifaf_pkg;

    localparam int VALUE_W           = 32;
    localparam int WIDTH_IN_W        = 6;
    localparam int CHAR_W            = 8;
    localparam int DIGIT_W           = 4;
    localparam int DIG_DEPTH         = 12;
    localparam int DIG_IDX_W         = 4;
    localparam int DEFAULT_MAX_WIDTH = 48;

    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [COND_W-1:0] cond_t;

    localparam op_t OP_NOP       = 4'd0;
    localparam op_t OP_LOAD      = 4'd1;
    localparam op_t OP_MUL       = 4'd2;
    localparam op_t OP_DIG       = 4'd3;
    localparam op_t OP_LEN       = 4'd4;
    localparam op_t OP_PAD_LEFT  = 4'd5;
    localparam op_t OP_SIGN      = 4'd6;
    localparam op_t OP_PAD_ZERO  = 4'd7;
    localparam op_t OP_DIGIT     = 4'd8;
    localparam op_t OP_PAD_RIGHT = 4'd9;

    localparam cond_t C_NEVER     = 4'd0;
    localparam cond_t C_ALWAYS    = 4'd1;
    localparam cond_t C_MORE_DIG  = 4'd2;
    localparam cond_t C_SKIP_PADL = 4'd3;
    localparam cond_t C_PAD_MORE  = 4'd4;
    localparam cond_t C_NO_SIGN   = 4'd5;
    localparam cond_t C_SKIP_PADZ = 4'd6;
    localparam cond_t C_DIG_MORE  = 4'd7;
    localparam cond_t C_SKIP_PADR = 4'd8;

    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } dp_ctrl_t;

    typedef struct packed {
        logic more_dig;
        logic pad_zero;
        logic pad_more;
        logic show_sign;
        logic left;
        logic zfill;
        logic dig_more;
    } dp_stat_t;

    function automatic logic is_emit(input op_t op);
        logic r;
        r = (op == OP_PAD_LEFT) || (op == OP_SIGN) || (op == OP_PAD_ZERO) ||
            (op == OP_DIGIT) || (op == OP_PAD_RIGHT);
        return r;
    endfunction

endpackage

[src/ifaf_rom.sv]
// Microcode store: one control word per sequencer step.
module ifaf_rom (
    input  ifaf_pkg::step_t  step,
    output ifaf_pkg::ucode_t word
);
    import ifaf_pkg::*;

    localparam step_t S_LOAD  = 4'd0;
    localparam step_t S_MUL   = 4'd1;
    localparam step_t S_DIG   = 4'd2;
    localparam step_t S_LEN   = 4'd3;
    localparam step_t S_TPADL = 4'd4;
    localparam step_t S_PADL  = 4'd5;
    localparam step_t S_TSIGN = 4'd6;
    localparam step_t S_SIGN  = 4'd7;
    localparam step_t S_TPADZ = 4'd8;
    localparam step_t S_PADZ  = 4'd9;
    localparam step_t S_DIGIT = 4'd10;
    localparam step_t S_TPADR = 4'd11;
    localparam step_t S_PADR  = 4'd12;
    localparam step_t S_DONE  = 4'd13;

    always_comb
    begin
        unique case (step)
            S_LOAD:  word = '{OP_LOAD,      C_NEVER,     S_LOAD};
            S_MUL:   word = '{OP_MUL,       C_NEVER,     S_LOAD};
            S_DIG:   word = '{OP_DIG,       C_MORE_DIG,  S_MUL};
            S_LEN:   word = '{OP_LEN,       C_NEVER,     S_LOAD};
            S_TPADL: word = '{OP_NOP,       C_SKIP_PADL, S_TSIGN};
            S_PADL:  word = '{OP_PAD_LEFT,  C_PAD_MORE,  S_PADL};
            S_TSIGN: word = '{OP_NOP,       C_NO_SIGN,   S_TPADZ};
            S_SIGN:  word = '{OP_SIGN,      C_NEVER,     S_LOAD};
            S_TPADZ: word = '{OP_NOP,       C_SKIP_PADZ, S_DIGIT};
            S_PADZ:  word = '{OP_PAD_ZERO,  C_PAD_MORE,  S_PADZ};
            S_DIGIT: word = '{OP_DIGIT,     C_DIG_MORE,  S_DIGIT};
            S_TPADR: word = '{OP_NOP,       C_SKIP_PADR, S_LOAD};
            S_PADR:  word = '{OP_PAD_RIGHT, C_PAD_MORE,  S_PADR};
            S_DONE:  word = '{OP_NOP,       C_ALWAYS,    S_LOAD};
            default: word = '{OP_NOP,       C_ALWAYS,    S_LOAD};
        endcase
    end

endmodule

[src/ifaf_seq.sv]
// Sequencer: step counter, condition test and jump over the microcode store.
module ifaf_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_free,
    input  ifaf_pkg::dp_stat_t stat,
    output ifaf_pkg::dp_ctrl_t ctrl,
    output logic               in_ready
);
    import ifaf_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t uw;
    logic   fire;
    logic   cond_true;

    ifaf_rom u_rom (
        .step (step_reg),
        .word (uw)
    );

    always_comb
    begin
        fire = 1'b1;
        if (uw.op == OP_LOAD)
            fire = in_valid;
        else if (is_emit(uw.op))
            fire = out_free;

        unique case (uw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_MORE_DIG:  cond_true = stat.more_dig;
            C_SKIP_PADL: cond_true = stat.left || stat.zfill || stat.pad_zero;
            C_PAD_MORE:  cond_true = stat.pad_more;
            C_NO_SIGN:   cond_true = !stat.show_sign;
            C_SKIP_PADZ: cond_true = stat.left || !stat.zfill || stat.pad_zero;
            C_DIG_MORE:  cond_true = stat.dig_more;
            C_SKIP_PADR: cond_true = !stat.left || stat.pad_zero;
            default:     cond_true = 1'b1;
        endcase

        if (!fire)
            step_next = step_reg;
        else if (cond_true)
            step_next = uw.target;
        else
            step_next = step_reg + 1'b1;

        ctrl.op   = uw.op;
        ctrl.fire = fire;
        in_ready  = (uw.op == OP_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

endmodule

[src/ifaf_dp.sv]
// Datapath: operand prep, digit extraction, digit stack, padding count and output register.
module ifaf_dp #(
    parameter int MAX_WIDTH = ifaf_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ifaf_pkg::dp_ctrl_t              ctrl,
    input  logic [ifaf_pkg::VALUE_W-1:0]    value,
    input  logic [1:0]                      base_code,
    input  logic [ifaf_pkg::WIDTH_IN_W-1:0] field_width,
    input  logic                            signed_mode,
    input  logic                            always_sign,
    input  logic                            zero_fill,
    input  logic                            left_justify,
    input  logic                            lower_hex,
    input  logic                            half_word,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [ifaf_pkg::CHAR_W-1:0]     out_char,
    output logic                            last_char,
    output logic                            out_free,
    output ifaf_pkg::dp_stat_t              stat
);
    import ifaf_pkg::*;

    localparam int PAD_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (PAD_W > WIDTH_IN_W) ? PAD_W : WIDTH_IN_W;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int DEC_SHIFT = 35;
    localparam logic [VALUE_W-1:0] RECIP_DEC = 32'hCCCC_CCCD;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] LOWER_BIT = 8'h20;
    localparam logic [CHAR_W-1:0] DIGIT_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    logic [VALUE_W-1:0]   mag_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [1:0]           base_reg;
    logic [PAD_W-1:0]     width_reg;
    logic                 neg_reg;
    logic                 show_sign_reg;
    logic                 zfill_reg;
    logic                 left_reg;
    logic                 lower_reg;
    logic [DIG_IDX_W-1:0] nd_reg;
    logic [PAD_W-1:0]     pad_reg;
    logic [DIGIT_W-1:0]   dig_reg [DIG_DEPTH];
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 last_reg;
    logic                 out_valid_reg;

    logic                 neg_in;
    logic [VALUE_W-1:0]   abs_in;
    logic [VALUE_W-1:0]   mag_in;
    logic [CMP_W-1:0]     fw_ext;
    logic [PAD_W-1:0]     width_in;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   rem_full;
    logic [DIGIT_W-1:0]   rem;
    logic [DIG_IDX_W-1:0] len;
    logic [PAD_W-1:0]     len_ext;
    logic [PAD_W-1:0]     pad_new;
    logic [DIG_IDX_W-1:0] nd_m1;
    logic [DIGIT_W-1:0]   top_digit;
    logic [CHAR_W-1:0]    emit_char;
    logic                 emit_last;
    logic                 emit_fire;
    logic                 do_fire;

    always_comb
    begin
        neg_in   = signed_mode & value[VALUE_W-1];
        abs_in   = neg_in ? (~value + 1'b1) : value;
        mag_in   = half_word ? {16'h0000, abs_in[15:0]} : abs_in;
        fw_ext   = CMP_W'(field_width);
        width_in = (fw_ext > CMP_W'(MAX_WIDTH)) ? PAD_W'(MAX_WIDTH) : fw_ext[PAD_W-1:0];

        case (base_reg)
            BASE_OCT:
            begin
                quot     = mag_reg >> 3;
                rem_full = {29'd0, mag_reg[2:0]};
            end
            BASE_DEC:
            begin
                quot     = {{DEC_SHIFT - VALUE_W{1'b0}}, prod_reg[PROD_W-1:DEC_SHIFT]};
                rem_full = mag_reg - ({quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0});
            end
            default:
            begin
                quot     = mag_reg >> 4;
                rem_full = {28'd0, mag_reg[3:0]};
            end
        endcase
        rem = rem_full[DIGIT_W-1:0];

        len     = nd_reg + {{DIG_IDX_W-1{1'b0}}, show_sign_reg};
        len_ext = PAD_W'(len);
        pad_new = (width_reg > len_ext) ? (width_reg - len_ext) : '0;

        nd_m1     = nd_reg - 1'b1;
        top_digit = dig_reg[nd_m1];

        emit_last = 1'b0;
        case (ctrl.op)
            OP_SIGN:     emit_char = neg_reg ? CH_MINUS : CH_PLUS;
            OP_PAD_ZERO: emit_char = CH_ZERO;
            OP_DIGIT:
            begin
                emit_char = DIGIT_TABLE[top_digit] | (lower_reg ? LOWER_BIT : '0);
                emit_last = (nd_reg == DIG_IDX_W'(1)) && (!left_reg || (pad_reg == '0));
            end
            OP_PAD_RIGHT:
            begin
                emit_char = CH_SPACE;
                emit_last = (pad_reg == PAD_W'(1));
            end
            default:     emit_char = CH_SPACE;
        endcase

        do_fire   = ctrl.fire;
        emit_fire = do_fire && is_emit(ctrl.op);
        out_free  = !out_valid_reg || out_ready;

        stat.more_dig  = (quot != '0) && (nd_reg < DIG_IDX_W'(DIG_DEPTH - 1));
        stat.pad_zero  = (pad_reg == '0);
        stat.pad_more  = (pad_reg > PAD_W'(1));
        stat.show_sign = show_sign_reg;
        stat.left      = left_reg;
        stat.zfill     = zfill_reg;
        stat.dig_more  = (nd_reg > DIG_IDX_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            nd_reg        <= '0;
            pad_reg       <= '0;
        end
        else
        begin
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (do_fire)
            begin
                case (ctrl.op)
                    OP_LOAD:   nd_reg <= '0;
                    OP_DIG:    nd_reg <= nd_reg + 1'b1;
                    OP_DIGIT:  nd_reg <= nd_m1;
                    default:   nd_reg <= nd_reg;
                endcase
                case (ctrl.op)
                    OP_LEN:                              pad_reg <= pad_new;
                    OP_PAD_LEFT, OP_PAD_ZERO, OP_PAD_RIGHT: pad_reg <= pad_reg - 1'b1;
                    default:                             pad_reg <= pad_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_fire && (ctrl.op == OP_LOAD))
        begin
            mag_reg       <= mag_in;
            base_reg      <= base_code;
            width_reg     <= width_in;
            neg_reg       <= neg_in;
            show_sign_reg <= neg_in | always_sign;
            zfill_reg     <= zero_fill;
            left_reg      <= left_justify;
            lower_reg     <= lower_hex;
        end
        if (do_fire && (ctrl.op == OP_MUL))
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP_DEC);
        if (do_fire && (ctrl.op == OP_DIG))
        begin
            dig_reg[nd_reg] <= rem;
            mag_reg         <= quot;
        end
        if (emit_fire)
        begin
            out_char_reg <= emit_char;
            last_reg     <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

endmodule

[src/integer_to_ascii_field_formatter.sv]
// Top level: printf-style integer field formatter, one ASCII character per output transaction.
// Items are taken one at a time: a new input is accepted only once the last character of the
//   previous one has been registered; the sequencer spends two steps per digit and one per character.
// The first character is registered after digit extraction and the padding count step.
// Output backpressure stalls the sequencer on its emit step; the next item is taken after the last.
// Reset: rst_n asynchronously returns the sequencer to its load step and clears output valid.
module integer_to_ascii_field_formatter #(
    parameter int MAX_WIDTH = ifaf_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], field_width[37:32], bits 39:38 unused
    input  logic [7:0]  s_tuser,   // base_code[1:0], signed_mode, always_sign, zero_fill,
                                   // left_justify, lower_hex, half_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char[7:0]
    output logic        m_tlast    // last_char
);
    import ifaf_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic     out_free;

    ifaf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (s_tready)
    );

    ifaf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .value        (s_tdata[31:0]),
        .base_code    (s_tuser[1:0]),
        .field_width  (s_tdata[37:32]),
        .signed_mode  (s_tuser[2]),
        .always_sign  (s_tuser[3]),
        .zero_fill    (s_tuser[4]),
        .left_justify (s_tuser[5]),
        .lower_hex    (s_tuser[6]),
        .half_word    (s_tuser[7]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_char     (m_tdata),
        .last_char    (m_tlast),
        .out_free     (out_free),
        .stat         (stat)
    );

endmodule
